/* rtl/core/sorted_list_priority_queue_defines.svh */
// ----------------------------------------------------------------------------
// sorted list priority queue assertion macros
// clocked property checks, removed when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_LIST_PRIORITY_QUEUE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property checked at every edge outside reset
`define SPLQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// property checked at every edge, reset included
`define SPLQ_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);
`else
`define SPLQ_ASSERT(lbl, prop, msg)
`define SPLQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* rtl/core/splq_pkg.sv */
// ----------------------------------------------------------------------------
// splq_pkg
// shared types and constants of the sorted list priority queue
// ----------------------------------------------------------------------------
package splq_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VAL_W    = 32;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_POP    = 2'd2
   } splq_cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_NOTFOUND = 2'd3
   } splq_status_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic              ins_en;
      logic              rem_en;
      logic              pop_en;
      logic [VAL_W-1:0]  value;
   } splq_ctrl_type;

   // per-cell compare results against the broadcast value
   typedef struct packed {
      logic gt;
      logic lt;
      logic match;
   } splq_flags_type;

endpackage

/* rtl/core/sorted_list_priority_queue.sv */
// ----------------------------------------------------------------------------
// sorted_list_priority_queue
// bounded ascending list of signed 32-bit values built as a chain of cells
//
// request channel (req_valid/req_ready) carries one command per beat:
// insert, remove one matching value, or pop the smallest value. every
// request beat yields exactly one response beat on rsp_valid/rsp_ready with
// a status, the popped value (zero unless a pop succeeded) and the entry
// count after the command.
// all cells compare against the request value in parallel, so a command
// completes in the cycle it is accepted; the response appears in the next
// cycle from the output register. a new request is taken every cycle while
// the response register is empty or being drained in that cycle, giving one
// command per cycle sustained. the rate is set by that single output
// register: when the receiver stalls, req_ready drops until the response
// beat is taken, and no command is lost or reordered.
// reset (synchronous, active high) empties the list at once and clears the
// response register; stored values need no clearing since only occupied
// cells are ever read.
// ----------------------------------------------------------------------------
`include "sorted_list_priority_queue_defines.svh"

module sorted_list_priority_queue import splq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_cmd,
   input  logic signed [31:0]       req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output logic signed [31:0]       rsp_popped_value,
   output logic [4:0]               rsp_entry_count
);

   // chain of cells
   logic                     cell_valid [CAPACITY];
   logic signed [VAL_W-1:0]  cell_data  [CAPACITY];
   splq_flags_type           cell_flags [CAPACITY];
   logic [CAPACITY-1:0]      valid_vec;
   logic [CAPACITY-1:0]      match_vec;

   // control
   splq_ctrl_type            ctrl;
   logic                     accept;
   logic                     found;
   logic                     is_full;
   logic                     is_empty;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic [31:0]              count_wide;

   // response register
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [1:0]               rsp_status_ff;
   logic [1:0]               rsp_status_in;
   logic signed [31:0]       rsp_popped_ff;
   logic signed [31:0]       rsp_popped_in;
   logic [4:0]               rsp_count_ff;
   logic [4:0]               rsp_count_in;

   // one-deep output buffer: take a request when it is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign is_full  = (count_ff == CNT_W'(CAPACITY));
   assign is_empty = (count_ff == '0);
   assign found    = |match_vec;

   always_comb begin
      ctrl          = '0;
      ctrl.value    = req_value;
      count_in      = count_ff;
      rsp_status_in = ST_OK;
      rsp_popped_in = '0;
      if (accept) begin
         unique case (splq_cmd_type'(req_cmd))
            CMD_INSERT: begin
               if (is_full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  ctrl.ins_en = 1'b1;
                  count_in    = count_ff + CNT_W'(1);
               end
            end
            CMD_REMOVE: begin
               if (is_empty) begin
                  rsp_status_in = ST_EMPTY;
               end else if (!found) begin
                  rsp_status_in = ST_NOTFOUND;
               end else begin
                  ctrl.rem_en = 1'b1;
                  count_in    = count_ff - CNT_W'(1);
               end
            end
            CMD_POP: begin
               if (is_empty) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  ctrl.pop_en   = 1'b1;
                  rsp_popped_in = cell_data[0];
                  count_in      = count_ff - CNT_W'(1);
               end
            end
            default: begin
               // unused command code: list untouched, status ok
            end
         endcase
      end
   end

   // entry count reported modulo 32
   assign count_wide   = 32'(count_in);
   assign rsp_count_in = count_wide[4:0];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic                     l_valid;
         logic                     l_gt;
         logic signed [VAL_W-1:0]  l_data;
         logic                     r_valid;
         logic signed [VAL_W-1:0]  r_data;

         if (gi == 0) begin : g_head
            // head cell: nothing to its left, new value enters here
            assign l_valid = 1'b1;
            assign l_gt    = 1'b0;
            assign l_data  = req_value;
         end else begin : g_body
            assign l_valid = cell_valid[gi-1];
            assign l_gt    = cell_flags[gi-1].gt;
            assign l_data  = cell_data[gi-1];
         end

         if (gi == CAPACITY - 1) begin : g_tail
            // tail cell: an empty slot shifts in from the right
            assign r_valid = 1'b0;
            assign r_data  = '0;
         end else begin : g_mid
            assign r_valid = cell_valid[gi+1];
            assign r_data  = cell_data[gi+1];
         end

         splq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .left_valid  (l_valid),
            .left_gt     (l_gt),
            .left_data   (l_data),
            .right_valid (r_valid),
            .right_data  (r_data),
            .valid       (cell_valid[gi]),
            .data        (cell_data[gi]),
            .flags       (cell_flags[gi])
         );

         assign valid_vec[gi] = cell_valid[gi];
         assign match_vec[gi] = cell_flags[gi].match;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, loaded only with a new beat
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_popped_ff <= rsp_popped_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_popped_value = rsp_popped_ff;
   assign rsp_entry_count  = rsp_count_ff;

   // occupied cells always form a prefix of the chain matching the count
   `SPLQ_ASSERT(a_prefix, ((valid_vec & (valid_vec + CAPACITY'(1))) == '0),
      "occupied cells are not a contiguous prefix")
   `SPLQ_ASSERT_ALWAYS(a_count, (reset || ($countones(valid_vec) == int'(count_ff))),
      "entry count disagrees with occupied cells")
   `SPLQ_ASSERT(a_pop_count, (accept && (req_cmd == CMD_POP) && !is_empty |=>
      count_ff == $past(count_ff) - CNT_W'(1)), "pop did not shrink the list by one")

endmodule

/* rtl/core/splq_cell.sv */
// ----------------------------------------------------------------------------
// splq_cell
// one slot of the sorted chain: holds a value, compares it with the
// broadcast value and shifts right on insert or left on delete
// ----------------------------------------------------------------------------
module splq_cell import splq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  splq_ctrl_type            ctrl,
   input  logic                     left_valid,
   input  logic                     left_gt,
   input  logic signed [VAL_W-1:0]  left_data,
   input  logic                     right_valid,
   input  logic signed [VAL_W-1:0]  right_data,
   output logic                     valid,
   output logic signed [VAL_W-1:0]  data,
   output splq_flags_type           flags
);

   logic                     valid_ff;
   logic                     valid_in;
   logic signed [VAL_W-1:0]  data_ff;
   logic signed [VAL_W-1:0]  data_in;
   logic signed [VAL_W-1:0]  key;
   logic                     shift_left;

   assign key = $signed(ctrl.value);

   // an empty slot counts as larger than anything
   assign flags.gt    = !valid_ff || (data_ff > key);
   assign flags.lt    = valid_ff && (data_ff < key);
   assign flags.match = valid_ff && (data_ff == key);

   assign shift_left = ctrl.pop_en || (ctrl.rem_en && !flags.lt);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (ctrl.ins_en && flags.gt) begin
         // first larger slot takes the new value, the rest take the left one
         data_in  = left_gt ? left_data : key;
         valid_in = valid_ff || left_valid;
      end else if (shift_left) begin
         data_in  = right_data;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// sorted list priority queue testbench
// drives insert, remove, pop and unused command beats into the block and
// checks every response beat against a behavioural copy of the sorted list
// kept in the bench. directed corner cases come first, then a fill under
// receiver back-pressure, then randomised fill and drain bursts under
// several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module tb;
   import splq_pkg::*;

   // code 3 has no package name: the block ignores it
   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   localparam int         STALL_LIMIT = 2000;
   localparam int         HOLD_CYCLES = 64;
   localparam logic signed [31:0] VAL_MAX = 32'sh7FFFFFFF;
   localparam logic signed [31:0] VAL_MIN = 32'sh80000000;

   // one expected response beat
   typedef struct {
      splq_status_type    status;
      logic signed [31:0] popped;
      logic [4:0]         count;
   } queue_result_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_cmd;
   logic signed [31:0] req_value;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_popped_value;
   logic [4:0]         rsp_entry_count;

   // bench copy of the list contents, in ascending signed order
   logic signed [31:0] shadow_list [CAPACITY];
   int                 shadow_count;

   queue_result_type   pending_results[$];
   int                 failures;
   int                 sender_idle_pct;
   int                 receiver_stall_pct;
   int                 hold_off_request;

   sorted_list_priority_queue u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_popped_value (rsp_popped_value),
      .rsp_entry_count  (rsp_entry_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // list behaviour
   // ------------------------------------------------------------------------

   // close the gap left by the entry at pos
   function automatic void drop_entry(input int pos);
      for (int k = pos; k + 1 < shadow_count; k++) shadow_list[k] = shadow_list[k + 1];
      shadow_count--;
   endfunction

   // applies one command to the bench list and returns the response it owes
   function automatic queue_result_type apply_to_list(input logic [1:0] cmd,
                                                      input logic signed [31:0] value);
      queue_result_type r;
      int               pos;
      r.status = ST_OK;
      r.popped = '0;
      case (cmd)
         CMD_INSERT: begin
            if (shadow_count >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               // new value goes after every equal one
               pos = 0;
               while (pos < shadow_count && shadow_list[pos] <= value) pos++;
               for (int k = shadow_count; k > pos; k--) shadow_list[k] = shadow_list[k - 1];
               shadow_list[pos] = value;
               shadow_count++;
            end
         end
         CMD_REMOVE: begin
            if (shadow_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               pos = 0;
               while (pos < shadow_count && shadow_list[pos] !== value) pos++;
               if (pos == shadow_count) r.status = ST_NOTFOUND;
               else drop_entry(pos);
            end
         end
         CMD_POP: begin
            if (shadow_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.popped = shadow_list[0];
               drop_entry(0);
            end
         end
         default: ; // unused code leaves the list alone and reports ok
      endcase
      r.count = 5'(shadow_count);
      return r;
   endfunction

   // value mix: a narrow band most often so that duplicates and matches are common,
   // some extremes, some full-range words; from_list picks a stored value
   function automatic logic signed [31:0] pick_value(input bit from_list);
      logic signed [31:0] v;
      if (from_list && shadow_count > 0) return shadow_list[$urandom_range(shadow_count - 1)];
      case ($urandom_range(9))
         0:         v = $urandom_range(1) ? VAL_MAX : VAL_MIN;
         1, 2, 3, 4: v = $signed($urandom_range(16)) - 8;
         5:         v = VAL_MAX - $urandom_range(3);
         6:         v = VAL_MIN + $urandom_range(3);
         default:   v = $urandom;
      endcase
      return v;
   endfunction

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------

   // offers one request beat, with random idle cycles first, and records the
   // expected response once the beat is taken; valid is left high on return so
   // that back-to-back beats need no gap
   task automatic send_command(input logic [1:0] cmd, input logic signed [31:0] value);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(apply_to_list(cmd, value));
   endtask

   // drop valid once a sequence of beats is over
   task automatic release_request();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------------

   // ready pattern; a hold-off request keeps ready low for a counted stretch
   initial begin : drive_receiver
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request > 0) begin
            stall_left       = hold_off_request;
            hold_off_request = 0;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   task automatic report_failure(input string msg);
      $display("error at %0t: %s", $realtime, msg);
      failures++;
   endtask

   // every response beat is matched against the oldest expectation
   always @(posedge clock) begin : check_results
      queue_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_failure("response beat with nothing outstanding");
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               report_failure($sformatf("status expected %0d got %0d",
                                        want.status, rsp_status));
            if (rsp_popped_value !== want.popped)
               report_failure($sformatf("popped value expected %0d got %0d",
                                        want.popped, rsp_popped_value));
            if (rsp_entry_count !== want.count)
               report_failure($sformatf("entry count expected %0d got %0d",
                                        want.count, rsp_entry_count));
         end
      end
   end

   // ends the run when neither channel moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // empty-list errors, extremes, duplicates, not-found, unused code
   task automatic test_directed_basics();
      send_command(CMD_POP, 32'sd0);          // pop on empty
      send_command(CMD_REMOVE, 32'sd0);       // remove on empty
      send_command(CMD_UNUSED, -32'sd1);      // ignored on empty
      send_command(CMD_INSERT, 32'sd0);
      send_command(CMD_INSERT, VAL_MAX);
      send_command(CMD_INSERT, VAL_MIN);
      send_command(CMD_INSERT, -32'sd1);
      send_command(CMD_INSERT, 32'sd0);       // equal value lands after the first
      send_command(CMD_INSERT, VAL_MAX);
      send_command(CMD_UNUSED, VAL_MIN);      // ignored with entries held
      send_command(CMD_REMOVE, 32'sd7);       // not found
      send_command(CMD_REMOVE, 32'sd0);       // one of two equal entries
      send_command(CMD_POP, VAL_MAX);         // smallest comes out, value ignored
      send_command(CMD_POP, 32'sd0);
      send_command(CMD_REMOVE, VAL_MAX);
      send_command(CMD_POP, 32'sd0);
      send_command(CMD_POP, 32'sd0);
      send_command(CMD_POP, 32'sd0);          // empty again
      release_request();
   endtask

   // receiver holds off while inserts keep coming, so the output register
   // fills and the request side stalls; one insert more than capacity is sent
   task automatic test_fill_under_backpressure();
      while (shadow_count > 0) send_command(CMD_POP, 32'sd0);
      hold_off_request = HOLD_CYCLES;
      repeat (CAPACITY + 1) send_command(CMD_INSERT, pick_value($urandom_range(1)));
      send_command(CMD_REMOVE, pick_value(1'b1));
      send_command(CMD_REMOVE, pick_value(1'b0));
      repeat (CAPACITY + 1) send_command(CMD_POP, $urandom);
      release_request();
   endtask

   // bursts biased towards filling, draining or a mix, so the list swings
   // between empty and full with plenty of matching removes
   task automatic test_random_traffic(input int n_items);
      int                 sent;
      int                 burst;
      int                 mode;
      int                 roll;
      logic [1:0]         cmd;
      logic signed [31:0] value;
      sent = 0;
      while (sent < n_items) begin
         mode  = $urandom_range(2);
         burst = $urandom_range(4, 24);
         repeat (burst) begin
            roll = $urandom_range(99);
            case (mode)
               0:       cmd = roll < 70 ? CMD_INSERT : roll < 85 ? CMD_REMOVE :
                              roll < 98 ? CMD_POP : CMD_UNUSED;
               1:       cmd = roll < 20 ? CMD_INSERT : roll < 55 ? CMD_REMOVE :
                              roll < 98 ? CMD_POP : CMD_UNUSED;
               default: cmd = roll < 40 ? CMD_INSERT : roll < 70 ? CMD_REMOVE :
                              roll < 98 ? CMD_POP : CMD_UNUSED;
            endcase
            // removes mostly aim at a stored value
            value = pick_value(cmd == CMD_REMOVE && $urandom_range(99) < 65);
            send_command(cmd, value);
            sent++;
         end
      end
      release_request();
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_cmd            = CMD_INSERT;
      req_value          = '0;
      shadow_count       = 0;
      failures           = 0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_off_request   = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_basics();
      test_fill_under_backpressure();

      // idling mixes: none, sender only, receiver only, both
      sender_idle_pct = 0;  receiver_stall_pct = 0;
      test_random_traffic(350);
      sender_idle_pct = 53; receiver_stall_pct = 0;
      test_random_traffic(350);
      sender_idle_pct = 0;  receiver_stall_pct = 53;
      test_random_traffic(350);
      sender_idle_pct = 32; receiver_stall_pct = 32;
      test_random_traffic(350);

      // let the last responses out, then watch a little longer for strays
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
